// ===== design/tbof_pkg.sv =====
// Package for the tracked box overlap filter.
// Holds the box type, operation codes, widths and the comparator result type.
// Depends on nothing; every other file of the block but tbof_out_if imports it.
`default_nettype none

package tbof_pkg;

  // Field widths of the transaction payload.
  localparam int unsigned COORD_W = 12;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned PCT_W   = 7;

  // Derived arithmetic widths: an edge sum, an area and a scaled area.
  localparam int unsigned EDGE_W = COORD_W + 1;
  localparam int unsigned AREA_W = 2 * COORD_W;
  localparam int unsigned PROD_W = AREA_W + PCT_W;

  // Threshold register reset value and the percent scale.
  localparam logic [PCT_W-1:0]  PCT_RESET = 7'd10;
  localparam logic [PROD_W-1:0] PCT_SCALE = 31'd100;

  // Operation codes of an input transaction.
  localparam logic OP_STORE = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  // One box: left and top edges, width and height.
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] h;
  } box_t;

  // Result of one slot comparison leaving the overlap pipeline.
  typedef struct packed {
    logic valid;
    logic hit;
  } tbof_res_t;

endpackage

`default_nettype wire

// ===== design/tbof_in_if.sv =====
// Input channel of the tracked box overlap filter: valid, ready and one item.
// Depends on tbof_pkg for the field widths.
`default_nettype none

interface tbof_in_if;
  import tbof_pkg::*;

  logic               valid;
  logic               ready;
  logic               operation;
  logic [SLOT_W-1:0]  slot;
  logic [COORD_W-1:0] box_x;
  logic [COORD_W-1:0] box_y;
  logic [COORD_W-1:0] box_width;
  logic [COORD_W-1:0] box_height;

  modport source (
    output valid, operation, slot, box_x, box_y, box_width, box_height,
    input  ready
  );

  modport sink (
    input  valid, operation, slot, box_x, box_y, box_width, box_height,
    output ready
  );

endinterface

`default_nettype wire

// ===== design/tbof_out_if.sv =====
// Result channel of the tracked box overlap filter: valid, ready and keep.
// No dependencies.
`default_nettype none

interface tbof_out_if;

  logic valid;
  logic ready;
  logic keep;

  modport source (
    output valid, keep,
    input  ready
  );

  modport sink (
    input  valid, keep,
    output ready
  );

endinterface

`default_nettype wire

// ===== design/tracked_box_overlap_filter_top.sv =====
// Tracked box overlap filter: a ring of tracked box cells and an overlap pipeline.
// Depends on tbof_pkg, tbof_in_if, tbof_out_if, tbof_cell and tbof_cmp.
//
// Usage: item_i carries store and check transactions. A store writes one box
// into a table slot (slots at or beyond MAX_TRACKED are ignored) and returns
// nothing. A check rotates the ring of MAX_TRACKED cells once, one cell a
// cycle into a four-stage overlap pipeline, and returns one keep bit on
// result_o. Keep follows the rotation, the four pipeline stages and the
// hand-off to the output register. item_i is ready only while no check is in
// progress, so a new check is taken only once the last one has handed off.
// The result register holds keep until result_o.ready; a store may be taken
// meanwhile, and a new check finishes only once the old result has left.
// cfg_we_i writes the overlap threshold in percent; write it only while idle.
// Reset empties every slot, sets the threshold to 10 and clears any result.
`default_nettype none

module tracked_box_overlap_filter_top #(
  parameter int unsigned MAX_TRACKED = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  tbof_in_if.sink                          item_i,
  tbof_out_if.source                       result_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [tbof_pkg::PCT_W-1:0]  cfg_data_i
);
  import tbof_pkg::*;

  localparam int unsigned CntW = (MAX_TRACKED > 1) ? $clog2(MAX_TRACKED) : 1;
  localparam logic [CntW-1:0] LastCnt = CntW'(MAX_TRACKED - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] launch_cnt_q;
  logic [CntW-1:0] ret_cnt_q;
  logic            hit_q;
  logic            out_valid_q;
  logic            keep_q;
  logic [PCT_W-1:0] pct_q;
  box_t            cand_q;

  logic            in_fire;
  logic            store_en;
  logic            shift;
  box_t            in_box;
  box_t            ring_box [MAX_TRACKED];
  tbof_res_t       res;

  assign item_i.ready = (state_q == ST_IDLE);
  assign in_fire      = item_i.valid && item_i.ready;
  assign store_en     = in_fire && (item_i.operation == OP_STORE);
  assign shift        = (state_q == ST_WALK);

  assign in_box.x = item_i.box_x;
  assign in_box.y = item_i.box_y;
  assign in_box.w = item_i.box_width;
  assign in_box.h = item_i.box_height;

  // Ring of cells; cell 0 feeds the comparator, each cell takes its upper neighbor.
  for (genvar i = 0; i < MAX_TRACKED; i++) begin : g_cell
    tbof_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .shift_i   (shift),
      .wr_en_i   (store_en && (32'(item_i.slot) == 32'(i))),
      .wr_box_i  (in_box),
      .nbr_box_i (ring_box[(i + 1) % MAX_TRACKED]),
      .box_o     (ring_box[i])
    );
  end

  // Overlap test pipeline.
  tbof_cmp u_cmp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (shift),
    .track_i (ring_box[0]),
    .cand_i  (cand_q),
    .pct_i   (pct_q),
    .res_o   (res)
  );

  // Threshold register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pct_q <= PCT_RESET;
    end else if (cfg_we_i) begin
      pct_q <= cfg_data_i;
    end
  end

  // Candidate box captured when a check is taken.
  always_ff @(posedge clk_i) begin
    if (in_fire && (item_i.operation == OP_CHECK)) begin
      cand_q <= in_box;
    end
  end

  // Check sequencer with the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      launch_cnt_q <= '0;
      ret_cnt_q    <= '0;
      hit_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      keep_q       <= 1'b0;
    end else begin
      if (out_valid_q && result_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_fire && (item_i.operation == OP_CHECK)) begin
            launch_cnt_q <= '0;
            ret_cnt_q    <= '0;
            hit_q        <= 1'b0;
            state_q      <= ST_WALK;
          end
        end
        ST_WALK: begin
          launch_cnt_q <= launch_cnt_q + 1'b1;
          if (launch_cnt_q == LastCnt) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state_q <= ST_DRAIN;
        end
        ST_DONE: begin
          if (!out_valid_q || result_o.ready) begin
            out_valid_q <= 1'b1;
            keep_q      <= !hit_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase

      // Collect comparison results; the last one ends the drain.
      if (res.valid) begin
        hit_q     <= hit_q | res.hit;
        ret_cnt_q <= ret_cnt_q + 1'b1;
        if (ret_cnt_q == LastCnt) begin
          state_q <= ST_DONE;
        end
      end
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.keep  = keep_q;

endmodule

`default_nettype wire

// ===== design/tbof_cell.sv =====
// One cell of the tracked box ring: holds one box, loads a stored box or
// takes its neighbor's box while the ring rotates. Depends on tbof_pkg.
`default_nettype none

module tbof_cell (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          shift_i,
  input  wire logic          wr_en_i,
  input  wire tbof_pkg::box_t wr_box_i,
  input  wire tbof_pkg::box_t nbr_box_i,
  output tbof_pkg::box_t     box_o
);
  import tbof_pkg::*;

  box_t box_q;
  box_t box_d;

  // A store has priority; stores arrive only while the ring is at rest.
  always_comb begin
    box_d = box_q;
    if (wr_en_i) begin
      box_d = wr_box_i;
    end else if (shift_i) begin
      box_d = nbr_box_i;
    end
  end

  // The table resets to empty boxes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q <= '0;
    end else begin
      box_q <= box_d;
    end
  end

  assign box_o = box_q;

endmodule

`default_nettype wire

// ===== design/tbof_cmp.sv =====
// Four-stage overlap test of one tracked box against the candidate box.
// Stages: edges, two areas, two scaled products, compare. Depends on tbof_pkg.
`default_nettype none

module tbof_cmp (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  valid_i,
  input  wire tbof_pkg::box_t        track_i,
  input  wire tbof_pkg::box_t        cand_i,
  input  wire logic [tbof_pkg::PCT_W-1:0] pct_i,
  output tbof_pkg::tbof_res_t        res_o
);
  import tbof_pkg::*;

  logic [COORD_W-1:0] left;
  logic [COORD_W-1:0] top;
  logic [EDGE_W-1:0]  t_right;
  logic [EDGE_W-1:0]  c_right;
  logic [EDGE_W-1:0]  t_bottom;
  logic [EDGE_W-1:0]  c_bottom;
  logic [EDGE_W-1:0]  right;
  logic [EDGE_W-1:0]  bottom;
  logic [EDGE_W-1:0]  dx_wide;
  logic [EDGE_W-1:0]  dy_wide;
  logic               ok_d;

  logic               v1_q, v2_q, v3_q;
  logic               ok1_q, ok2_q, ok3_q;
  logic [COORD_W-1:0] dx1_q, dy1_q, tw1_q, th1_q;
  logic [AREA_W-1:0]  inter2_q, area2_q;
  logic [PROD_W-1:0]  lhs3_q, rhs3_q;
  logic               res_valid_q;
  logic               res_hit_q;

  // Intersection edges and the non-empty test.
  always_comb begin
    left     = (track_i.x > cand_i.x) ? track_i.x : cand_i.x;
    top      = (track_i.y > cand_i.y) ? track_i.y : cand_i.y;
    t_right  = {1'b0, track_i.x} + {1'b0, track_i.w};
    c_right  = {1'b0, cand_i.x} + {1'b0, cand_i.w};
    t_bottom = {1'b0, track_i.y} + {1'b0, track_i.h};
    c_bottom = {1'b0, cand_i.y} + {1'b0, cand_i.h};
    right    = (t_right < c_right) ? t_right : c_right;
    bottom   = (t_bottom < c_bottom) ? t_bottom : c_bottom;
    dx_wide  = right - {1'b0, left};
    dy_wide  = bottom - {1'b0, top};
    ok_d     = (track_i.w != '0) && (track_i.h != '0) &&
               (right > {1'b0, left}) && (bottom > {1'b0, top});
  end

  // Valid flags of the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      v1_q        <= valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      res_valid_q <= v3_q;
    end
  end

  // Data path; the overlap width never exceeds the tracked width, so 12 bits hold it.
  always_ff @(posedge clk_i) begin
    ok1_q     <= ok_d;
    dx1_q     <= dx_wide[COORD_W-1:0];
    dy1_q     <= dy_wide[COORD_W-1:0];
    tw1_q     <= track_i.w;
    th1_q     <= track_i.h;

    ok2_q     <= ok1_q;
    inter2_q  <= {{COORD_W{1'b0}}, dx1_q} * {{COORD_W{1'b0}}, dy1_q};
    area2_q   <= {{COORD_W{1'b0}}, tw1_q} * {{COORD_W{1'b0}}, th1_q};

    ok3_q     <= ok2_q;
    lhs3_q    <= {{PCT_W{1'b0}}, inter2_q} * PCT_SCALE;
    rhs3_q    <= {{AREA_W{1'b0}}, pct_i} * {{PCT_W{1'b0}}, area2_q};

    res_hit_q <= ok3_q && (lhs3_q >= rhs3_q);
  end

  assign res_o.valid = res_valid_q;
  assign res_o.hit   = res_hit_q;

endmodule

`default_nettype wire

// ===== tb/tracked_box_overlap_filter_top_tb.sv =====
// Testbench for tracked_box_overlap_filter_top: store and check transactions, random stalls.
// Uses tbof_pkg, tbof_in_if and tbof_out_if from the design. Keep bits are checked
// against a table model of the tracked boxes and the threshold, or typed per directed row.
`default_nettype none

module tracked_box_overlap_filter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tbof_pkg::*;

  localparam int unsigned MAX_TRACKED    = 16;
  localparam int unsigned CLK_PERIOD     = 4;
  localparam int unsigned RESET_CYCLES   = 4;
  localparam int unsigned SETTLE_CYCLES  = MAX_TRACKED + 12;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned PHASE_ITEMS    = 200;
  localparam int unsigned NUM_PHASES     = 9;
  localparam int unsigned HOLD_PHASE     = 3;
  localparam int          COORD_MAX      = (1 << COORD_W) - 1;

  // Directed stimulus rows: a threshold write or one transaction.
  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_e;
  typedef enum logic {EXP_MODEL, EXP_TYPED} exp_src_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [PCT_W-1:0]   pct;
    logic               op;
    logic [SLOT_W-1:0]  slot;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] h;
    exp_src_e           src;
    logic               keep;
  } stim_row_t;

  localparam int unsigned NUM_DIRECTED = 28;

  stim_row_t directed_rows [NUM_DIRECTED] = '{
    // Empty table after reset: everything is kept.
    '{ROW_ITEM, 0, OP_CHECK, 0, 0, 0, 0, 0, EXP_TYPED, 1'b1},
    '{ROW_ITEM, 0, OP_CHECK, 15, 4095, 4095, 4095, 4095, EXP_TYPED, 1'b1},
    '{ROW_ITEM, 0, OP_CHECK, 0, 0, 0, 4095, 4095, EXP_TYPED, 1'b1},
    // One tracked box, an identical candidate and empty candidates.
    '{ROW_ITEM, 0, OP_STORE, 0, 100, 100, 100, 100, EXP_MODEL, 1'b0},
    '{ROW_ITEM, 0, OP_CHECK, 0, 100, 100, 100, 100, EXP_TYPED, 1'b0},
    '{ROW_ITEM, 0, OP_CHECK, 0, 100, 100, 0, 100, EXP_TYPED, 1'b1},
    '{ROW_ITEM, 0, OP_CHECK, 0, 100, 100, 100, 0, EXP_TYPED, 1'b1},
    // A zero-area slot never matches.
    '{ROW_ITEM, 0, OP_STORE, 15, 300, 300, 0, 50, EXP_MODEL, 1'b0},
    '{ROW_ITEM, 0, OP_CHECK, 0, 300, 300, 50, 50, EXP_TYPED, 1'b1},
    // Largest box at the far corner.
    '{ROW_ITEM, 0, OP_STORE, 1, 4095, 4095, 4095, 4095, EXP_MODEL, 1'b0},
    '{ROW_ITEM, 0, OP_CHECK, 7, 4095, 4095, 4095, 4095, EXP_TYPED, 1'b0},
    '{ROW_ITEM, 0, OP_CHECK, 0, 0, 0, 4095, 4095, EXP_MODEL, 1'b0},
    // Threshold zero: any overlap drops, touching edges do not.
    '{ROW_CFG, 0, OP_STORE, 0, 0, 0, 0, 0, EXP_MODEL, 1'b0},
    '{ROW_ITEM, 0, OP_CHECK, 0, 199, 199, 1, 1, EXP_MODEL, 1'b0},
    '{ROW_ITEM, 0, OP_CHECK, 0, 200, 100, 10, 10, EXP_TYPED, 1'b1},
    // Full coverage required.
    '{ROW_CFG, 100, OP_STORE, 0, 0, 0, 0, 0, EXP_MODEL, 1'b0},
    '{ROW_ITEM, 0, OP_CHECK, 0, 100, 100, 100, 100, EXP_MODEL, 1'b0},
    '{ROW_ITEM, 0, OP_CHECK, 0, 100, 100, 100, 99, EXP_MODEL, 1'b0},
    // Thresholds above one hundred can never be met.
    '{ROW_CFG, 127, OP_STORE, 0, 0, 0, 0, 0, EXP_MODEL, 1'b0},
    '{ROW_ITEM, 0, OP_CHECK, 0, 100, 100, 100, 100, EXP_TYPED, 1'b1},
    '{ROW_CFG, 101, OP_STORE, 0, 0, 0, 0, 0, EXP_MODEL, 1'b0},
    '{ROW_ITEM, 0, OP_CHECK, 0, 4095, 4095, 4095, 4095, EXP_TYPED, 1'b1},
    // Exact boundary of a half overlap.
    '{ROW_CFG, 50, OP_STORE, 0, 0, 0, 0, 0, EXP_MODEL, 1'b0},
    '{ROW_ITEM, 0, OP_CHECK, 0, 150, 100, 100, 100, EXP_MODEL, 1'b0},
    '{ROW_ITEM, 0, OP_CHECK, 0, 151, 100, 100, 100, EXP_MODEL, 1'b0},
    // Overwriting a slot with an empty box removes it.
    '{ROW_ITEM, 0, OP_STORE, 0, 0, 0, 0, 0, EXP_MODEL, 1'b0},
    '{ROW_ITEM, 0, OP_CHECK, 0, 100, 100, 100, 100, EXP_MODEL, 1'b0},
    '{ROW_CFG, 10, OP_STORE, 0, 0, 0, 0, 0, EXP_MODEL, 1'b0}
  };

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [PCT_W-1:0] cfg_data_i;

  tbof_in_if  item_if ();
  tbof_out_if result_if ();

  tracked_box_overlap_filter_top #(
    .MAX_TRACKED(MAX_TRACKED)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (item_if),
    .result_o  (result_if),
    .cfg_we_i  (cfg_we_i),
    .cfg_data_i(cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Model state: the tracked table and the threshold register.
  box_t             tracked_table [MAX_TRACKED];
  logic [PCT_W-1:0] overlap_pct_model;
  logic             keep_expected_q [$];

  int unsigned error_count   = 0;
  int unsigned store_count   = 0;
  int unsigned check_count   = 0;
  int unsigned kept_count    = 0;
  int unsigned dropped_count = 0;
  int unsigned cfg_count     = 0;
  int unsigned hold_count    = 0;
  int unsigned idle_cycles   = 0;
  bit          hold_request  = 1'b0;

  // Does tracked box t count as covering candidate c at threshold pct?
  function automatic logic slot_covers(box_t t, box_t c, logic [PCT_W-1:0] pct);
    logic [EDGE_W-1:0] left;
    logic [EDGE_W-1:0] top;
    logic [EDGE_W-1:0] right;
    logic [EDGE_W-1:0] bottom;
    logic [EDGE_W-1:0] t_right;
    logic [EDGE_W-1:0] c_right;
    logic [EDGE_W-1:0] t_bottom;
    logic [EDGE_W-1:0] c_bottom;
    logic [63:0]       area;
    logic [63:0]       inter;
    left     = (t.x > c.x) ? EDGE_W'(t.x) : EDGE_W'(c.x);
    top      = (t.y > c.y) ? EDGE_W'(t.y) : EDGE_W'(c.y);
    t_right  = EDGE_W'(t.x) + EDGE_W'(t.w);
    c_right  = EDGE_W'(c.x) + EDGE_W'(c.w);
    t_bottom = EDGE_W'(t.y) + EDGE_W'(t.h);
    c_bottom = EDGE_W'(c.y) + EDGE_W'(c.h);
    right    = (t_right < c_right) ? t_right : c_right;
    bottom   = (t_bottom < c_bottom) ? t_bottom : c_bottom;
    area     = 64'(t.w) * 64'(t.h);
    if (area == 64'd0 || right <= left || bottom <= top) begin
      return 1'b0;
    end
    inter = 64'(right - left) * 64'(bottom - top);
    return (inter * 64'd100) >= (64'(pct) * area);
  endfunction

  // A candidate is kept when no tracked slot covers it.
  function automatic logic predict_keep(box_t c);
    for (int i = 0; i < MAX_TRACKED; i++) begin
      if (slot_covers(tracked_table[i], c, overlap_pct_model)) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Idle gap length: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [COORD_W-1:0] clamp_coord(int v);
    if (v < 0) begin
      return '0;
    end else if (v > COORD_MAX) begin
      return COORD_W'(COORD_MAX);
    end
    return COORD_W'(v);
  endfunction

  // Offer one transaction after an idle gap; on acceptance update the model.
  task automatic send_item(input logic op, input logic [SLOT_W-1:0] slot, input box_t b,
                           input int unsigned gap, input exp_src_e src,
                           input logic typed_keep);
    if (gap > 0) begin
      item_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    item_if.valid      = 1'b1;
    item_if.operation  = op;
    item_if.slot       = slot;
    item_if.box_x      = b.x;
    item_if.box_y      = b.y;
    item_if.box_width  = b.w;
    item_if.box_height = b.h;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    if (op == OP_STORE) begin
      if (slot < MAX_TRACKED) begin
        tracked_table[slot] = b;
      end
      store_count++;
    end else begin
      keep_expected_q.insert(keep_expected_q.size(),
                             (src == EXP_TYPED) ? typed_keep : predict_keep(b));
      check_count++;
    end
    @(negedge clk_i);
  endtask

  // Threshold write, only once the block has drained and settled.
  task automatic write_threshold(input logic [PCT_W-1:0] pct);
    item_if.valid = 1'b0;
    while (keep_expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_data_i = pct;
    @(negedge clk_i);
    cfg_we_i          = 1'b0;
    overlap_pct_model = pct;
    cfg_count++;
  endtask

  // Result side: random stalls, runs of steady ready, and one long hold-off on request.
  initial begin
    int unsigned stall;
    int unsigned run;
    stall           = 0;
    run             = 0;
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        result_if.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_request = 1'b0;
        hold_count++;
      end else if (stall > 0) begin
        result_if.ready = 1'b0;
        stall--;
      end else begin
        result_if.ready = 1'b1;
        if (run > 0) begin
          run--;
        end else if ($urandom_range(0, 49) == 0) begin
          run = 100;
        end else begin
          stall = pick_gap();
        end
      end
    end
  end

  // Result checker and watchdog, both sampling at the rising edge.
  always @(posedge clk_i) begin
    logic exp_keep;
    if (rst_ni) begin
      if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (result_if.valid && result_if.ready) begin
        if (keep_expected_q.size() == 0) begin
          $display("%0t: unexpected result transaction, keep %0b", $realtime,
                   result_if.keep);
          error_count++;
        end else begin
          exp_keep = keep_expected_q.pop_front();
          if (result_if.keep !== exp_keep) begin
            $display("%0t: keep mismatch, expected %0b actual %0b", $realtime,
                     exp_keep, result_if.keep);
            error_count++;
          end
          if (exp_keep) begin
            kept_count++;
          end else begin
            dropped_count++;
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                 $realtime, idle_cycles, keep_expected_q.size());
        $display("FAIL tracked_box_overlap_filter_top");
        $finish;
      end
    end
  end

  // Main sequence: reset, directed rows, then random phases at several thresholds.
  initial begin
    logic [PCT_W-1:0]   phase_pct [NUM_PHASES];
    box_t               b;
    box_t               t;
    logic               op;
    logic [SLOT_W-1:0]  slot;
    int unsigned        r;
    int unsigned        gap;
    int                 spread;
    int                 delta;

    item_if.valid      = 1'b0;
    item_if.operation  = OP_STORE;
    item_if.slot       = '0;
    item_if.box_x      = '0;
    item_if.box_y      = '0;
    item_if.box_width  = '0;
    item_if.box_height = '0;
    cfg_we_i           = 1'b0;
    cfg_data_i         = PCT_RESET;
    rst_ni             = 1'b0;
    overlap_pct_model  = PCT_RESET;
    foreach (tracked_table[i]) tracked_table[i] = '0;

    phase_pct = '{7'd10, 7'd0, 7'd100, 7'd127, 7'd50, 7'd1, 7'd99,
                  PCT_W'($urandom_range(0, 127)), 7'd25};

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_threshold(directed_rows[i].pct);
      end else begin
        b = '{x: directed_rows[i].x, y: directed_rows[i].y,
              w: directed_rows[i].w, h: directed_rows[i].h};
        send_item(directed_rows[i].op, directed_rows[i].slot, b, pick_gap(),
                  directed_rows[i].src, directed_rows[i].keep);
      end
    end

    // Random part. Odd phases offer back to back; one of them meets a long hold-off.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      write_threshold(phase_pct[phase]);
      if (phase == HOLD_PHASE) begin
        hold_request = 1'b1;
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r    = $urandom_range(0, 99);
        slot = SLOT_W'($urandom_range(0, (1 << SLOT_W) - 1));
        if (r < 25) begin
          // Store: mostly modest boxes, some empty, some of any size.
          op  = OP_STORE;
          b.x = COORD_W'($urandom_range(0, COORD_MAX));
          b.y = COORD_W'($urandom_range(0, COORD_MAX));
          r   = $urandom_range(0, 99);
          b.w = (r < 5) ? '0 : (r < 12) ? COORD_W'($urandom_range(0, COORD_MAX))
                                        : COORD_W'($urandom_range(1, 400));
          r   = $urandom_range(0, 99);
          b.h = (r < 5) ? '0 : (r < 12) ? COORD_W'($urandom_range(0, COORD_MAX))
                                        : COORD_W'($urandom_range(1, 400));
        end else if (r < 70) begin
          // Check near a tracked box: shifted and resized around it.
          op     = OP_CHECK;
          t      = tracked_table[$urandom_range(0, MAX_TRACKED - 1)];
          spread = int'(t.w) / 2 + 4;
          delta  = int'($urandom_range(0, 2 * spread)) - spread;
          b.x    = clamp_coord(int'(t.x) + delta);
          spread = int'(t.h) / 2 + 4;
          delta  = int'($urandom_range(0, 2 * spread)) - spread;
          b.y    = clamp_coord(int'(t.y) + delta);
          spread = int'(t.w) / 4 + 2;
          delta  = int'($urandom_range(0, 2 * spread)) - spread;
          b.w    = clamp_coord(int'(t.w) + delta);
          spread = int'(t.h) / 4 + 2;
          delta  = int'($urandom_range(0, 2 * spread)) - spread;
          b.h    = clamp_coord(int'(t.h) + delta);
        end else begin
          // Check anywhere: any size, sometimes empty.
          op  = OP_CHECK;
          b.x = COORD_W'($urandom_range(0, COORD_MAX));
          b.y = COORD_W'($urandom_range(0, COORD_MAX));
          b.w = COORD_W'($urandom_range(0, COORD_MAX));
          b.h = COORD_W'($urandom_range(0, COORD_MAX));
          if (r >= 95) begin
            b.w = '0;
          end
        end
        gap = (phase % 2 == 1) ? 0 : pick_gap();
        send_item(op, slot, b, gap, EXP_MODEL, 1'b0);
      end
    end

    // Drain and let the pipeline settle so that stray results would show.
    item_if.valid = 1'b0;
    while (keep_expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Covered %0d stores and %0d checks (%0d kept, %0d dropped)",
             store_count, check_count, kept_count, dropped_count);
    $display("over %0d threshold writes and %0d long result hold-off(s); %0d errors",
             cfg_count, hold_count, error_count);
    if (error_count == 0) begin
      $display("PASS tracked_box_overlap_filter_top");
    end else begin
      $display("FAIL tracked_box_overlap_filter_top");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
design/tbof_pkg.sv
design/tbof_in_if.sv
design/tbof_out_if.sv
design/tbof_cell.sv
design/tbof_cmp.sv
design/tracked_box_overlap_filter_top.sv
tb/tracked_box_overlap_filter_top_tb.sv
